[rtl/core/fssa_pkg.sv]
// Shared types and codes for the fit-strategy segment allocator.
`timescale 1ns / 1ps
package fssa_pkg;
    // Pool and table limits; the port widths are built around these.
    localparam int POOL_BYTES   = 65536;
    localparam int MAX_SEGMENTS = 64;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BADFR = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int unsigned REG_STRATEGY  = 0;
    localparam int unsigned REG_POOL_SIZE = 1;
endpackage

[rtl/core/fssa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module fssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered; a read of the entry written in the same cycle returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/fit_strategy_segment_allocator.sv]
// Top level of the fit-strategy segment allocator: sequencer around the segment table RAM.
//
// Usage:
//   Input channel (valid/ready) carries one word: operation, request_size, free_address.
//   Output channel (valid/ready) returns one word per input word: status, address and
//   pool statistics after the request.
//   Configuration channel writes strategy (index 0) or pool_size (index 1); writing
//   pool_size rebuilds the table as one free segment. It is taken only while idle.
//   Each word runs through a sequencer around one table RAM holding start, length and
//   used flag per entry. Every RAM read takes an address state and then a data state; with
//   N segments a word takes a search pass over up to N entries, a shift pass for a split or
//   a merge, and a statistics pass over all N entries.
//   One word is in flight at a time; the next word is accepted at the earliest in the
//   cycle after the result has been taken.
//   Reset builds the table as one free segment covering POOL_BYTES, strategy first fit.
//   The result sits in an output register; a stalled receiver holds it there and
//   the block takes no new word until it is delivered.
`timescale 1ns / 1ps
module fit_strategy_segment_allocator
    import fssa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [16:0] request_size,
    input  logic [15:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] address,
    output logic [16:0] free_bytes,
    output logic [16:0] allocated_bytes,
    output logic [16:0] largest_free,
    output logic [6:0]  hole_count
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 16 + 17 + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SRCH  = 5'd1;
    localparam logic [4:0] S_SRCHW = 5'd2;
    localparam logic [4:0] S_DEC   = 5'd3;
    localparam logic [4:0] S_SHR   = 5'd4;
    localparam logic [4:0] S_SHRW  = 5'd5;
    localparam logic [4:0] S_WPICK = 5'd6;
    localparam logic [4:0] S_WREST = 5'd7;
    localparam logic [4:0] S_NRD   = 5'd8;
    localparam logic [4:0] S_NRDW  = 5'd9;
    localparam logic [4:0] S_MWR   = 5'd10;
    localparam logic [4:0] S_SHL   = 5'd11;
    localparam logic [4:0] S_SHLW  = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_STAT  = 5'd14;
    localparam logic [4:0] S_STATW = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0]    state_reg;
    logic [1:0]    strategy_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] resume_reg;
    logic          op_reg;
    logic [16:0]   req_reg;
    logic [15:0]   faddr_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic          found_reg;
    logic [AW-1:0] cand_reg;
    logic [AW-1:0] pick_reg;
    logic [15:0]   pstart_reg;
    logic [16:0]   plen_reg;
    logic [EW-1:0] prev_reg;
    logic          next_free_reg;
    logic [16:0]   next_len_reg;
    logic [1:0]    shift_reg;
    logic [15:0]   addr_reg;
    logic [1:0]    st_reg;
    logic [16:0]   freeb_reg, usedb_reg, largest_reg;
    logic [6:0]    holes_reg;
    logic          init_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [15:0]   r_start;
    logic [16:0]   r_len;
    logic          r_used;
    logic          cfg_fire, in_fire;
    logic [CW-1:0] scan_pos;
    logic [CW:0]   scan_sum;
    logic          fit_now, better;
    logic [16:0]   pool_cfg;
    logic          split;
    logic [15:0]   rest_start;
    logic [16:0]   rest_len;
    logic          prev_free;
    logic [AW-1:0] tgt_addr;
    logic [15:0]   tgt_start;
    logic [16:0]   tgt_len;
    logic [1:0]    merge_shift;
    logic [CW-1:0] res_tmp;
    logic [AW-1:0] resume_merge;

    fssa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign r_start = rdata[EW-1 -: 16];
    assign r_len   = rdata[17:1];
    assign r_used  = rdata[0];

    assign cfg_ready = (state_reg == S_IDLE) && !init_reg;
    assign in_ready  = (state_reg == S_IDLE) && !init_reg && !cfg_valid;
    assign out_valid = (state_reg == S_OUT);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign status          = st_reg;
    assign address         = addr_reg;
    assign free_bytes      = freeb_reg;
    assign allocated_bytes = usedb_reg;
    assign largest_free    = largest_reg;
    assign hole_count      = holes_reg;

    // Scan position for the search pass (next fit wraps).
    always_comb
    begin
        scan_sum = {1'b0, idx_reg} + {1'b0, n_reg};
        if (scan_sum >= {1'b0, count_reg})
        begin
            scan_sum = scan_sum - {1'b0, count_reg};
        end
        scan_pos = scan_sum[CW-1:0];
    end

    // Candidate test for the entry just read.
    always_comb
    begin
        fit_now = !r_used && (r_len >= req_reg);
        better  = 1'b0;
        if (op_reg == OP_FREE)
        begin
            fit_now = r_used && (r_start == faddr_reg);
        end
        if (fit_now)
        begin
            unique case (strategy_reg)
                FIT_BEST:  better = !found_reg || (r_len < plen_reg);
                FIT_WORST: better = !found_reg || (r_len > plen_reg);
                default:   better = !found_reg;
            endcase
            if (op_reg == OP_FREE)
            begin
                better = !found_reg;
            end
        end
    end

    // Pool size written through the configuration channel, clamped to the legal range.
    always_comb
    begin
        pool_cfg = cfg_data;
        if (pool_cfg == 17'd0)
        begin
            pool_cfg = 17'd1;
        end
        if ({15'd0, pool_cfg} > 32'(POOL_BYTES))
        begin
            pool_cfg = 17'(POOL_BYTES);
        end
    end

    // Split of the chosen segment into the used front and the free rest.
    assign split      = plen_reg > req_reg;
    assign rest_start = pstart_reg + req_reg[15:0];
    assign rest_len   = plen_reg - req_reg;

    // Merge of a freed segment with its free neighbors.
    always_comb
    begin
        prev_free   = (pick_reg != '0) && !prev_reg[0];
        tgt_addr    = prev_free ? pick_reg - AW'(1) : pick_reg;
        tgt_start   = prev_free ? prev_reg[EW-1 -: 16] : pstart_reg;
        tgt_len     = plen_reg + (prev_free ? prev_reg[17:1] : 17'd0)
                      + (next_free_reg ? next_len_reg : 17'd0);
        merge_shift = {1'b0, prev_free} + {1'b0, next_free_reg};
        res_tmp     = CW'(resume_reg);
        if (next_free_reg && res_tmp >= CW'(pick_reg) + CW'(1) && res_tmp != '0)
        begin
            res_tmp = res_tmp - CW'(1);
        end
        if (prev_free && res_tmp >= CW'(pick_reg) && res_tmp != '0)
        begin
            res_tmp = res_tmp - CW'(1);
        end
        resume_merge = res_tmp[AW-1:0];
    end

    // Address and write port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (init_reg || (cfg_fire && cfg_index == 1'(REG_POOL_SIZE)))
                begin
                    we    = 1'b1;
                    wdata = {16'd0, (init_reg ? 17'(POOL_BYTES) : pool_cfg), 1'b0};
                end
            end
            S_SRCH:  raddr = scan_pos[AW-1:0];
            S_SHR:   raddr = idx_reg[AW-1:0];
            S_SHRW:
            begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0] + AW'(1);
                wdata = rdata;
            end
            S_WPICK:
            begin
                we    = 1'b1;
                waddr = pick_reg;
                wdata = {pstart_reg, (split ? req_reg : plen_reg), 1'b1};
            end
            S_WREST:
            begin
                we    = 1'b1;
                waddr = pick_reg + AW'(1);
                wdata = {rest_start, rest_len, 1'b0};
            end
            S_NRD:   raddr = pick_reg + AW'(1);
            S_MWR:
            begin
                we    = 1'b1;
                waddr = tgt_addr;
                wdata = {tgt_start, tgt_len, 1'b0};
            end
            S_SHL:   raddr = idx_reg[AW-1:0];
            S_SHLW:
            begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0] - AW'(shift_reg);
                wdata = rdata;
            end
            S_STAT:  raddr = idx_reg[AW-1:0];
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            strategy_reg  <= FIT_FIRST;
            count_reg     <= CW'(1);
            resume_reg    <= '0;
            init_reg      <= 1'b1;
            st_reg        <= ST_OK;
            found_reg     <= 1'b0;
            op_reg        <= OP_ALLOC;
            req_reg       <= '0;
            faddr_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            cand_reg      <= '0;
            pick_reg      <= '0;
            pstart_reg    <= '0;
            plen_reg      <= '0;
            prev_reg      <= '0;
            next_free_reg <= 1'b0;
            next_len_reg  <= '0;
            shift_reg     <= '0;
            addr_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    init_reg <= 1'b0;
                    if (cfg_fire)
                    begin
                        if (cfg_index == 1'(REG_STRATEGY))
                        begin
                            strategy_reg <= cfg_data[1:0];
                        end
                        else
                        begin
                            count_reg  <= CW'(1);
                            resume_reg <= '0;
                        end
                    end
                    else if (in_fire)
                    begin
                        op_reg     <= operation;
                        req_reg    <= request_size;
                        faddr_reg  <= free_address;
                        found_reg  <= 1'b0;
                        n_reg      <= '0;
                        pstart_reg <= '0;
                        plen_reg   <= '0;
                        addr_reg   <= '0;
                        idx_reg    <= (operation == OP_ALLOC && strategy_reg == FIT_NEXT
                                       && CW'(resume_reg) < count_reg) ? CW'(resume_reg) : '0;
                        if (operation == OP_ALLOC && request_size == 17'd0)
                        begin
                            st_reg    <= ST_NOFIT;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    cand_reg  <= scan_pos[AW-1:0];
                    state_reg <= S_SRCHW;
                end
                // The entry before a match is kept for the merge of a free request.
                S_SRCHW:
                begin
                    if (better)
                    begin
                        found_reg  <= 1'b1;
                        pick_reg   <= cand_reg;
                        pstart_reg <= r_start;
                        plen_reg   <= r_len;
                    end
                    else
                    begin
                        prev_reg <= rdata;
                    end
                    if ((better && (strategy_reg == FIT_FIRST || strategy_reg == FIT_NEXT
                         || op_reg == OP_FREE)) || n_reg + CW'(1) >= count_reg)
                    begin
                        state_reg <= S_DEC;
                    end
                    else
                    begin
                        n_reg     <= n_reg + CW'(1);
                        state_reg <= S_SRCH;
                    end
                end
                S_DEC:
                begin
                    if (!found_reg)
                    begin
                        st_reg    <= (op_reg == OP_FREE) ? ST_BADFR : ST_NOFIT;
                        state_reg <= S_FIN;
                    end
                    else if (op_reg == OP_ALLOC)
                    begin
                        if (split && count_reg >= CW'(MAX_SEGMENTS))
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            st_reg    <= ST_OK;
                            idx_reg   <= count_reg - CW'(1);
                            state_reg <= split ? S_SHR : S_WPICK;
                        end
                    end
                    else
                    begin
                        st_reg    <= ST_OK;
                        state_reg <= S_NRD;
                    end
                end
                // Split: shift entries above the pick up by one, then write pick and rest.
                S_SHR:
                begin
                    if (idx_reg <= CW'(pick_reg))
                    begin
                        state_reg <= S_WPICK;
                    end
                    else
                    begin
                        state_reg <= S_SHRW;
                    end
                end
                S_SHRW:
                begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= S_SHR;
                end
                S_WPICK:
                begin
                    addr_reg <= pstart_reg;
                    if (split)
                    begin
                        state_reg <= S_WREST;
                    end
                    else
                    begin
                        resume_reg <= (CW'(pick_reg) + CW'(1) < count_reg)
                                      ? pick_reg + AW'(1) : '0;
                        state_reg  <= S_FIN;
                    end
                end
                S_WREST:
                begin
                    count_reg  <= count_reg + CW'(1);
                    resume_reg <= pick_reg + AW'(1);
                    state_reg  <= S_FIN;
                end
                // Free: look at the following entry, write the merged entry, close the gap.
                S_NRD: state_reg <= S_NRDW;
                S_NRDW:
                begin
                    next_free_reg <= (CW'(pick_reg) + CW'(1) < count_reg) && !r_used;
                    next_len_reg  <= r_len;
                    state_reg     <= S_MWR;
                end
                S_MWR:
                begin
                    shift_reg  <= merge_shift;
                    resume_reg <= resume_merge;
                    idx_reg    <= CW'(pick_reg) + CW'(1) + CW'(next_free_reg);
                    state_reg  <= (merge_shift == 2'd0) ? S_FIN : S_SHL;
                end
                S_SHL:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(shift_reg);
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SHLW;
                    end
                end
                S_SHLW:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_SHL;
                end
                S_FIN:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_STAT;
                end
                S_STAT:
                begin
                    state_reg <= S_STATW;
                end
                S_STATW:
                begin
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_STAT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Statistics accumulation during the final pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freeb_reg   <= '0;
            usedb_reg   <= '0;
            largest_reg <= '0;
            holes_reg   <= '0;
        end
        else if (state_reg == S_FIN)
        begin
            freeb_reg   <= '0;
            usedb_reg   <= '0;
            largest_reg <= '0;
            holes_reg   <= '0;
        end
        else if (state_reg == S_STATW)
        begin
            if (r_used)
            begin
                usedb_reg <= usedb_reg + r_len;
            end
            else
            begin
                freeb_reg <= freeb_reg + r_len;
                holes_reg <= holes_reg + 7'd1;
                if (r_len > largest_reg)
                begin
                    largest_reg <= r_len;
                end
            end
        end
    end

    // Output holds while stalled.
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_excl;
        @(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid);
    endproperty
    a_excl: assert property (p_excl) else $error("input taken while result pending");

    property p_count;
        @(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CW'(MAX_SEGMENTS);
    endproperty
    a_count: assert property (p_count) else $error("segment count out of range");
endmodule
